### design/i2cms_pkg.sv
// i2cms_pkg: types, codes and microcode layout shared by the I2C master bit sequencer.
// No dependencies; the sequencer, the microcode ROM and the bench import this package.
package i2cms_pkg;

    localparam int PC_W        = 5;
    localparam int CYC_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = 3;
    localparam logic [CYC_W-1:0]     PHASE_CYCLES_RST = 16'd720;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT         = 3'd7;
    localparam logic [PC_W-1:0]      LOOP_BACK        = 5'd2;

    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_SEND_ACK = 3'd4,
        OP_READ_ACK = 3'd5
    } op_t;

    // Microcode entry points
    localparam logic [PC_W-1:0] UC_START    = 5'd0;
    localparam logic [PC_W-1:0] UC_STOP     = 5'd4;
    localparam logic [PC_W-1:0] UC_WRITE    = 5'd7;
    localparam logic [PC_W-1:0] UC_READ     = 5'd10;
    localparam logic [PC_W-1:0] UC_SEND_ACK = 5'd13;
    localparam logic [PC_W-1:0] UC_READ_ACK = 5'd16;

    typedef enum logic [1:0] {
        SCL_KEEP,
        SCL_LO,
        SCL_HI
    } scl_op_t;

    typedef enum logic [2:0] {
        SDA_KEEP,
        SDA_LO,
        SDA_HI,
        SDA_TX,
        SDA_ACK
    } sda_op_t;

    // One control word per bus phase
    typedef struct packed {
        scl_op_t scl;
        sda_op_t sda;
        logic    sample;
        logic    loop;      // jump back two steps until the eighth bit
        logic    fin;       // final phase of the command
        logic    emit_rx;
        logic    emit_ack;
    } ucode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HOLD
    } seq_state_t;

endpackage

### design/i2cms_cmd_if.sv
// i2cms_cmd_if: command channel of the I2C master bit sequencer.
// Depends on nothing; valid/ready handshake with the command payload.
interface i2cms_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic [7:0] sda_samples;

    modport source (output valid, op, tx_byte, ack_out, sda_samples, input ready);
    modport sink   (input valid, op, tx_byte, ack_out, sda_samples, output ready);
endinterface

### design/i2cms_phase_if.sv
// i2cms_phase_if: per-phase result channel of the I2C master bit sequencer.
// Depends on nothing; valid/ready handshake with one bus phase word.
interface i2cms_phase_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       sample_now;
    logic       last;
    logic [7:0] rx_byte;
    logic       ack_in;

    modport source (output valid, scl_out, sda_out, sample_now, last, rx_byte, ack_in,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, sample_now, last, rx_byte, ack_in,
                    output ready);
endinterface

### design/i2c_master_bit_sequencer.sv
// i2c_master_bit_sequencer: top level, microcoded bit-level I2C master.
// Depends on i2cms_pkg, i2cms_cmd_if, i2cms_phase_if and i2cms_ucode_rom.
//
// One command word is taken at a time and turned into its run of bus phase words
// (start 4, stop 3, write/read byte 24, send ack 3, read ack 4), each naming the SCL
// and SDA levels to drive. A step counter walks a microprogram ROM, one control word
// per phase; byte commands loop over three steps eight times. Each phase is executed
// in ST_EXEC and then held in ST_HOLD while a counter loaded from phase_cycles runs down
// (0 acts as 1), and the next phase waits until the previous phase word has left the
// output register. Unused op codes are accepted and give no phase words. SCL and SDA
// levels persist between commands and come out of reset released (1).
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CYC_W-1:0]    cfg_wdata,
    i2cms_cmd_if.sink           cmd,
    i2cms_phase_if.source       phase
);

    seq_state_t             state_reg, state_next;
    logic [PC_W-1:0]        pc_reg, pc_next;
    logic [BIT_CNT_W-1:0]   bit_reg, bit_next;
    logic [CYC_W-1:0]       cnt_reg, cnt_next;
    logic [CYC_W-1:0]       phase_cycles_reg;
    logic                   done_reg, done_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      tx_reg, tx_next;
    logic [BYTE_W-1:0]      smp_reg, smp_next;
    logic                   ack_reg, ack_next;
    logic                   o_scl_reg, o_scl_next;
    logic                   o_sda_reg, o_sda_next;
    logic                   o_sample_reg, o_sample_next;
    logic                   o_last_reg, o_last_next;
    logic [BYTE_W-1:0]      o_rx_reg, o_rx_next;
    logic                   o_ack_reg, o_ack_next;

    ucode_t                 ctrl;
    logic                   slot_free;
    logic                   last_phase;
    logic                   lvl_scl, lvl_sda;

    i2cms_ucode_rom u_rom
    (
        .pc   (pc_reg),
        .ctrl (ctrl)
    );

    assign slot_free  = !out_valid_reg || phase.ready;
    assign last_phase = ctrl.fin || (ctrl.loop && bit_reg == LAST_BIT);

    always_comb
    begin
        case (ctrl.scl)
            SCL_LO:  lvl_scl = 1'b0;
            SCL_HI:  lvl_scl = 1'b1;
            default: lvl_scl = scl_reg;
        endcase
        case (ctrl.sda)
            SDA_LO:  lvl_sda = 1'b0;
            SDA_HI:  lvl_sda = 1'b1;
            SDA_TX:  lvl_sda = tx_reg[BYTE_W-1];
            SDA_ACK: lvl_sda = ack_reg;
            default: lvl_sda = sda_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        tx_next        = tx_reg;
        smp_next       = smp_reg;
        ack_next       = ack_reg;
        out_valid_next = out_valid_reg && !phase.ready;
        o_scl_next     = o_scl_reg;
        o_sda_next     = o_sda_reg;
        o_sample_next  = o_sample_reg;
        o_last_next    = o_last_reg;
        o_rx_next      = o_rx_reg;
        o_ack_next     = o_ack_reg;
        cmd.ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    tx_next   = cmd.tx_byte;
                    smp_next  = cmd.sda_samples;
                    ack_next  = cmd.ack_out;
                    bit_next  = '0;
                    done_next = 1'b0;
                    state_next = ST_EXEC;
                    case (op_t'(cmd.op))
                        OP_START:    pc_next = UC_START;
                        OP_STOP:     pc_next = UC_STOP;
                        OP_WRITE:    pc_next = UC_WRITE;
                        OP_READ:     pc_next = UC_READ;
                        OP_SEND_ACK: pc_next = UC_SEND_ACK;
                        OP_READ_ACK: pc_next = UC_READ_ACK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC:
            begin
                // wait for the output register, then drive this phase
                if (slot_free)
                begin
                    scl_next       = lvl_scl;
                    sda_next       = lvl_sda;
                    out_valid_next = 1'b1;
                    o_scl_next     = lvl_scl;
                    o_sda_next     = lvl_sda;
                    o_sample_next  = ctrl.sample;
                    o_last_next    = last_phase;
                    o_rx_next      = (ctrl.emit_rx && last_phase) ? smp_reg : '0;
                    o_ack_next     = ctrl.emit_ack ? smp_reg[BYTE_W-1] : 1'b0;
                    cnt_next       = phase_cycles_reg;
                    state_next     = ST_HOLD;
                    if (last_phase)
                    begin
                        done_next = 1'b1;
                    end
                    else if (ctrl.loop)
                    begin
                        pc_next  = pc_reg - LOOP_BACK;
                        bit_next = bit_reg + 1'b1;
                        tx_next  = {tx_reg[BYTE_W-2:0], 1'b0};
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            ST_HOLD:
            begin
                if (cnt_reg <= 16'd1)
                    state_next = done_reg ? ST_IDLE : ST_EXEC;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pc_reg           <= '0;
            bit_reg          <= '0;
            cnt_reg          <= '0;
            done_reg         <= 1'b0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
            out_valid_reg    <= 1'b0;
            phase_cycles_reg <= PHASE_CYCLES_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            bit_reg       <= bit_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                phase_cycles_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg       <= tx_next;
        smp_reg      <= smp_next;
        ack_reg      <= ack_next;
        o_scl_reg    <= o_scl_next;
        o_sda_reg    <= o_sda_next;
        o_sample_reg <= o_sample_next;
        o_last_reg   <= o_last_next;
        o_rx_reg     <= o_rx_next;
        o_ack_reg    <= o_ack_next;
    end

    assign phase.valid      = out_valid_reg;
    assign phase.scl_out    = o_scl_reg;
    assign phase.sda_out    = o_sda_reg;
    assign phase.sample_now = o_sample_reg;
    assign phase.last       = o_last_reg;
    assign phase.rx_byte    = o_rx_reg;
    assign phase.ack_in     = o_ack_reg;

endmodule

### design/i2cms_ucode_rom.sv
// i2cms_ucode_rom: read-only microprogram, one control word per bus phase.
// Depends on i2cms_pkg for the control word layout and entry points.
module i2cms_ucode_rom
    import i2cms_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output ucode_t          ctrl
);

    always_comb
    begin
        ctrl = '{scl: SCL_KEEP, sda: SDA_KEEP, sample: 1'b0, loop: 1'b0,
                 fin: 1'b0, emit_rx: 1'b0, emit_ack: 1'b0};
        case (pc)
            // start
            5'd0:  ctrl.sda = SDA_HI;
            5'd1:  ctrl.scl = SCL_HI;
            5'd2:  ctrl.sda = SDA_LO;
            5'd3:
            begin
                ctrl.scl = SCL_LO;
                ctrl.fin = 1'b1;
            end
            // stop
            5'd4:  ctrl.sda = SDA_LO;
            5'd5:  ctrl.scl = SCL_HI;
            5'd6:
            begin
                ctrl.sda = SDA_HI;
                ctrl.fin = 1'b1;
            end
            // write byte, one bit per pass
            5'd7:  ctrl.sda = SDA_TX;
            5'd8:  ctrl.scl = SCL_HI;
            5'd9:
            begin
                ctrl.scl  = SCL_LO;
                ctrl.loop = 1'b1;
            end
            // read byte
            5'd10: ctrl.scl = SCL_HI;
            5'd11: ctrl.sample = 1'b1;
            5'd12:
            begin
                ctrl.scl     = SCL_LO;
                ctrl.loop    = 1'b1;
                ctrl.emit_rx = 1'b1;
            end
            // send ack
            5'd13: ctrl.sda = SDA_ACK;
            5'd14: ctrl.scl = SCL_HI;
            5'd15:
            begin
                ctrl.scl = SCL_LO;
                ctrl.fin = 1'b1;
            end
            // read ack
            5'd16: ctrl.sda = SDA_HI;
            5'd17: ctrl.scl = SCL_HI;
            5'd18: ctrl.sample = 1'b1;
            5'd19:
            begin
                ctrl.scl      = SCL_LO;
                ctrl.fin      = 1'b1;
                ctrl.emit_ack = 1'b1;
            end
            default: ctrl.fin = 1'b1;
        endcase
    end

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for the I2C master bit sequencer.
// Depends on i2cms_pkg, i2cms_cmd_if, i2cms_phase_if and the sequencer RTL.
// Commands go in from a queue and every phase word out is checked against a bus-level predictor.
module tb_top
    import i2cms_pkg::*;
();

    localparam logic [2:0] OP_SPARE_LO   = 3'd6;
    localparam logic [2:0] OP_SPARE_HI   = 3'd7;
    localparam int         LONG_HOLD      = 300;
    localparam int         LATENCY_PAD    = 20;
    localparam int         WATCHDOG_LIMIT = 300000;

    typedef struct {
        logic [2:0] op;
        logic [7:0] tx;
        logic       ack;
        logic [7:0] smp;
    } cmd_word_t;

    typedef struct {
        logic       scl;
        logic       sda;
        logic       sample;
        logic       last;
        logic [7:0] rx;
        logic       ack;
    } phase_word_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CYC_W-1:0] cfg_wdata;

    i2cms_cmd_if   cmd_bus();
    i2cms_phase_if phase_bus();

    i2c_master_bit_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_bus),
        .phase     (phase_bus)
    );

    cmd_word_t   cmd_pending[$];
    phase_word_t expected_phases[$];

    // predictor copy of the bus levels and the phase length
    logic        scl_lvl;
    logic        sda_lvl;
    int unsigned phase_len;

    int          items_queued;
    int          mismatches;
    bit          calm;
    int          hold_reqs;
    int          holds_served;
    int          hold_left;
    int          stall_left;
    int          send_gap;
    int          quiet_cycles;
    cmd_word_t   next_cmd;

    always #2 clk = ~clk;

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom);
    endfunction

    function automatic void push_phase(logic sample, logic last, logic [7:0] rx, logic ack);
        phase_word_t w;
        w.scl    = scl_lvl;
        w.sda    = sda_lvl;
        w.sample = sample;
        w.last   = last;
        w.rx     = rx;
        w.ack    = ack;
        expected_phases.push_back(w);
    endfunction

    function automatic void predict_phases(logic [2:0] op, logic [7:0] tx, logic ack_bit,
                                           logic [7:0] smp);
        logic [7:0] rx;
        int         i;
        rx = '0;
        case (op)
            OP_START:
            begin
                sda_lvl = 1'b1; push_phase(1'b0, 1'b0, '0, 1'b0);
                scl_lvl = 1'b1; push_phase(1'b0, 1'b0, '0, 1'b0);
                sda_lvl = 1'b0; push_phase(1'b0, 1'b0, '0, 1'b0);
                scl_lvl = 1'b0; push_phase(1'b0, 1'b1, '0, 1'b0);
            end
            OP_STOP:
            begin
                sda_lvl = 1'b0; push_phase(1'b0, 1'b0, '0, 1'b0);
                scl_lvl = 1'b1; push_phase(1'b0, 1'b0, '0, 1'b0);
                sda_lvl = 1'b1; push_phase(1'b0, 1'b1, '0, 1'b0);
            end
            OP_WRITE:
            begin
                for (i = 7; i >= 0; i--)
                begin
                    sda_lvl = tx[i];  push_phase(1'b0, 1'b0, '0, 1'b0);
                    scl_lvl = 1'b1;   push_phase(1'b0, 1'b0, '0, 1'b0);
                    scl_lvl = 1'b0;   push_phase(1'b0, i == 0, '0, 1'b0);
                end
            end
            OP_READ:
            begin
                // SDA is left at whatever level the previous command held
                for (i = 7; i >= 0; i--)
                begin
                    scl_lvl = 1'b1;
                    push_phase(1'b0, 1'b0, '0, 1'b0);
                    rx[i] = smp[i];
                    push_phase(1'b1, 1'b0, '0, 1'b0);
                    scl_lvl = 1'b0;
                    push_phase(1'b0, i == 0, (i == 0) ? rx : 8'h00, 1'b0);
                end
            end
            OP_SEND_ACK:
            begin
                sda_lvl = ack_bit; push_phase(1'b0, 1'b0, '0, 1'b0);
                scl_lvl = 1'b1;    push_phase(1'b0, 1'b0, '0, 1'b0);
                scl_lvl = 1'b0;    push_phase(1'b0, 1'b1, '0, 1'b0);
            end
            OP_READ_ACK:
            begin
                sda_lvl = 1'b1; push_phase(1'b0, 1'b0, '0, 1'b0);
                scl_lvl = 1'b1; push_phase(1'b0, 1'b0, '0, 1'b0);
                push_phase(1'b1, 1'b0, '0, 1'b0);
                scl_lvl = 1'b0; push_phase(1'b0, 1'b1, '0, smp[7]);
            end
            default:
            begin
                // spare op codes: no phases, levels untouched
            end
        endcase
    endfunction

    function automatic void add_cmd(logic [2:0] op, logic [7:0] tx, logic ack_bit,
                                    logic [7:0] smp);
        cmd_word_t w;
        w.op  = op;
        w.tx  = tx;
        w.ack = ack_bit;
        w.smp = smp;
        cmd_pending.push_back(w);
        if (op <= OP_READ_ACK)
            items_queued++;
    endfunction

    // start, address, ack, a few data bytes each with their ack, optional repeated start, stop
    function automatic void queue_transaction();
        logic [7:0] addr;
        int         beats;
        int         k;
        addr  = rnd_byte();
        beats = $urandom_range(1, 4);
        add_cmd(OP_START, rnd_byte(), 1'($urandom), rnd_byte());
        add_cmd(OP_WRITE, addr, 1'($urandom), rnd_byte());
        add_cmd(OP_READ_ACK, rnd_byte(), 1'($urandom), rnd_byte());
        for (k = 0; k < beats; k++)
        begin
            if (addr[0])
            begin
                add_cmd(OP_READ, rnd_byte(), 1'($urandom), rnd_byte());
                add_cmd(OP_SEND_ACK, rnd_byte(), (k == beats - 1) ? 1'b1 : 1'($urandom),
                        rnd_byte());
            end
            else
            begin
                add_cmd(OP_WRITE, rnd_byte(), 1'($urandom), rnd_byte());
                add_cmd(OP_READ_ACK, rnd_byte(), 1'($urandom), rnd_byte());
            end
        end
        if ($urandom_range(0, 5) == 0)
            add_cmd(OP_START, rnd_byte(), 1'($urandom), rnd_byte());
        add_cmd(OP_STOP, rnd_byte(), 1'($urandom), rnd_byte());
    endfunction

    task automatic drain();
        while (cmd_pending.size() != 0 || cmd_bus.valid || expected_phases.size() != 0)
            @(negedge clk);
        // the last phase may still be held inside the block
        repeat (((phase_len == 0) ? 1 : phase_len) + LATENCY_PAD) @(negedge clk);
    endtask

    task automatic set_phase_cycles(logic [CYC_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        phase_len = val;
        @(negedge clk);
    endtask

    task automatic run_random(int upto, bit with_hold);
        while (items_queued < upto)
        begin
            if ($urandom_range(0, 7) == 0)
                add_cmd(3'($urandom_range(0, 7)), rnd_byte(), 1'($urandom), rnd_byte());
            else
                queue_transaction();
        end
        if (with_hold)
            hold_reqs++;
        drain();
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // command driver: predict on every accepted word, then offer the next one after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid       <= 1'b0;
            cmd_bus.op          <= OP_START;
            cmd_bus.tx_byte     <= '0;
            cmd_bus.ack_out     <= 1'b0;
            cmd_bus.sda_samples <= '0;
            send_gap = 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                predict_phases(cmd_bus.op, cmd_bus.tx_byte, cmd_bus.ack_out,
                               cmd_bus.sda_samples);
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_bus.valid <= 1'b0;
                end
                else if (cmd_pending.size() != 0)
                begin
                    next_cmd = cmd_pending.pop_front();
                    cmd_bus.op          <= next_cmd.op;
                    cmd_bus.tx_byte     <= next_cmd.tx;
                    cmd_bus.ack_out     <= next_cmd.ack;
                    cmd_bus.sda_samples <= next_cmd.smp;
                    cmd_bus.valid       <= 1'b1;
                    send_gap = draw_wait();
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // phase monitor: check each accepted word, then stall or serve a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_bus.ready <= 1'b0;
            stall_left   = 0;
            hold_left    = 0;
            holds_served = 0;
        end
        else
        begin
            if (phase_bus.valid && phase_bus.ready)
            begin
                if (expected_phases.size() == 0)
                begin
                    $error("phase word with no expectation pending");
                    mismatches++;
                end
                else
                begin
                    phase_word_t w;
                    w = expected_phases.pop_front();
                    check_field("scl_out", w.scl, phase_bus.scl_out);
                    check_field("sda_out", w.sda, phase_bus.sda_out);
                    check_field("sample_now", w.sample, phase_bus.sample_now);
                    check_field("last", w.last, phase_bus.last);
                    check_field("rx_byte", w.rx, phase_bus.rx_byte);
                    check_field("ack_in", w.ack, phase_bus.ack_in);
                end
                stall_left = draw_wait();
            end
            if (holds_served != hold_reqs)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                phase_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                phase_bus.ready <= 1'b0;
            end
            else
                phase_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (phase_bus.valid && phase_bus.ready)
            || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("i2c_master_bit_sequencer test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        scl_lvl      = 1'b1;
        sda_lvl      = 1'b1;
        phase_len    = PHASE_CYCLES_RST;
        items_queued = 0;
        mismatches   = 0;
        calm         = 1'b0;
        hold_reqs    = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // short exchange at the reset phase length
        add_cmd(OP_START, 8'h00, 1'b0, 8'h00);
        add_cmd(OP_WRITE, 8'hA5, 1'b0, 8'h00);
        add_cmd(OP_READ_ACK, 8'h00, 1'b0, 8'h00);
        add_cmd(OP_STOP, 8'h00, 1'b0, 8'h00);
        drain();

        set_phase_cycles(16'd1);
        // read byte right after stop (SDA released) and after start (SDA low)
        add_cmd(OP_READ, 8'h00, 1'b0, 8'hFF);
        add_cmd(OP_START, 8'hFF, 1'b1, 8'hFF);
        add_cmd(OP_READ, 8'hFF, 1'b1, 8'h00);
        add_cmd(OP_WRITE, 8'h00, 1'b1, 8'hFF);
        add_cmd(OP_WRITE, 8'hFF, 1'b0, 8'h00);
        add_cmd(OP_WRITE, 8'h80, 1'b0, 8'h55);
        add_cmd(OP_WRITE, 8'h01, 1'b1, 8'hAA);
        add_cmd(OP_READ_ACK, 8'h00, 1'b0, 8'h80);
        add_cmd(OP_READ_ACK, 8'hFF, 1'b1, 8'h7F);
        add_cmd(OP_SEND_ACK, 8'hFF, 1'b1, 8'h00);
        add_cmd(OP_READ, 8'h00, 1'b0, 8'hA5);
        add_cmd(OP_SEND_ACK, 8'h00, 1'b0, 8'hFF);
        add_cmd(OP_READ, 8'h00, 1'b1, 8'h5A);
        add_cmd(OP_SPARE_LO, rnd_byte(), 1'($urandom), rnd_byte());
        add_cmd(OP_SPARE_HI, rnd_byte(), 1'($urandom), rnd_byte());
        add_cmd(OP_START, 8'h00, 1'b0, 8'h00);
        add_cmd(OP_START, 8'h00, 1'b0, 8'h00);
        add_cmd(OP_STOP, 8'h00, 1'b0, 8'h00);
        add_cmd(OP_STOP, 8'h00, 1'b0, 8'h00);
        add_cmd(OP_SEND_ACK, 8'h00, 1'b0, 8'h00);
        add_cmd(OP_SPARE_HI, 8'hFF, 1'b1, 8'hFF);
        add_cmd(OP_READ_ACK, 8'h00, 1'b0, 8'h00);
        drain();

        run_random(150, 1'b1);

        set_phase_cycles(16'd0);
        calm = 1'b1;
        run_random(230, 1'b0);
        calm = 1'b0;

        set_phase_cycles(16'hFFFF);
        add_cmd(OP_STOP, rnd_byte(), 1'($urandom), rnd_byte());
        drain();

        set_phase_cycles(16'd3);
        run_random(330, 1'b1);

        set_phase_cycles(16'd2);
        run_random(410, 1'b0);

        if (mismatches == 0 && expected_phases.size() == 0)
            $display("i2c_master_bit_sequencer test passed");
        else
            $display("i2c_master_bit_sequencer test failed");
        $finish;
    end
endmodule

### files.f
design/i2cms_pkg.sv
design/i2cms_cmd_if.sv
design/i2cms_phase_if.sv
design/i2cms_ucode_rom.sv
design/i2c_master_bit_sequencer.sv
bench/tb_top.sv
